// ===== rtl/core/sfb_pkg.sv =====
// ----------------------------------------------------------------------------
// sfb_pkg
// Shared types and constants of the stereo FIR filter bank.
// ----------------------------------------------------------------------------
`default_nettype none

package sfb_pkg;

    localparam int DATA_W    = 32;
    localparam int NUM_FILT  = 6;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRE_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT    = 2'd2;

    // input beat kinds
    localparam logic MODE_PAIR = 1'b0;
    localparam logic MODE_LOAD = 1'b1;

    // coefficient banks
    localparam logic [1:0] BANK_LP  = 2'd0;
    localparam logic [1:0] BANK_HP  = 2'd1;
    localparam logic [1:0] BANK_BP  = 2'd2;
    localparam logic [1:0] BANK_NUM = 2'd3;

    // issue word for the multiply-accumulate unit
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
        logic gain;
    } mac_ctl_t;

    // bank used by each filter: left LP, HP, BP then right BP, HP, LP
    function automatic logic [1:0] filt_bank(input logic [2:0] f);
        logic [1:0] b;
        case (f)
            3'd0:    b = BANK_LP;
            3'd1:    b = BANK_HP;
            3'd2:    b = BANK_BP;
            3'd3:    b = BANK_BP;
            3'd4:    b = BANK_HP;
            default: b = BANK_LP;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sfb_ram.sv =====
// ----------------------------------------------------------------------------
// sfb_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sfb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/core/sfb_mac.sv =====
// ----------------------------------------------------------------------------
// sfb_mac
// Shared multiply-accumulate unit: Q1.31 products floored to Q31, wide sum,
// saturated result.
// ----------------------------------------------------------------------------
`default_nettype none

module sfb_mac
    import sfb_pkg::*;
#(
    parameter int MAX_TAPS = 64
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire mac_ctl_t                 ctl,
    input  wire logic signed [DATA_W-1:0] gain_x,
    input  wire logic signed [DATA_W-1:0] pre_gain,
    input  wire logic signed [DATA_W-1:0] coef,
    input  wire logic signed [DATA_W-1:0] hist,
    output logic                          res_vld,
    output logic signed [DATA_W-1:0]      res
);

    localparam int ACC_W = 34 + $clog2(MAX_TAPS);
    localparam int TERM_W = DATA_W + 1;

    mac_ctl_t                        ctl1_reg;
    logic signed [2*DATA_W-1:0]      prod_reg;
    logic signed [ACC_W-1:0]         acc_reg;
    logic                            done_reg;
    logic signed [DATA_W-1:0]        opa;
    logic signed [DATA_W-1:0]        opb;
    logic signed [2*DATA_W-1:0]      shifted;
    logic signed [TERM_W-1:0]        term;
    logic signed [ACC_W-1:0]         acc_next;
    logic [ACC_W-DATA_W:0]           hi;

    // operand select
    assign opa = ctl.gain ? gain_x : coef;
    assign opb = ctl.gain ? pre_gain : hist;

    // floor to Q31 and accumulate
    assign shifted  = prod_reg >>> (DATA_W - 1);
    assign term     = shifted[TERM_W-1:0];
    assign acc_next = (ctl1_reg.first ? ACC_W'(0) : acc_reg)
                    + {{(ACC_W-TERM_W){term[TERM_W-1]}}, term};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ctl1_reg <= ctl;
            done_reg <= ctl1_reg.vld & ctl1_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= opa * opb;
        if (ctl1_reg.vld)
        begin
            acc_reg <= acc_next;
        end
    end

    // saturate to Q1.31
    assign hi      = acc_reg[ACC_W-1:DATA_W-1];
    assign res_vld = done_reg;
    always_comb
    begin
        if ((&hi) || !(|hi))
            res = acc_reg[DATA_W-1:0];
        else if (acc_reg[ACC_W-1])
            res = {1'b1, {(DATA_W-1){1'b0}}};
        else
            res = {1'b0, {(DATA_W-1){1'b1}}};
    end

endmodule

`default_nettype wire

// ===== rtl/core/sfb_ctrl.sv =====
// ----------------------------------------------------------------------------
// sfb_ctrl
// Sequencer: input beats, delay line and coefficient addressing, write
// positions, MAC issue and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sfb_ctrl
    import sfb_pkg::*;
#(
    parameter int MAX_TAPS = 64
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // input channel
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic                                 mode,
    input  wire logic signed [DATA_W-1:0]             sample_left,
    input  wire logic signed [DATA_W-1:0]             sample_right,
    input  wire logic [1:0]                           coeff_bank,
    input  wire logic [5:0]                           coeff_index,
    input  wire logic signed [DATA_W-1:0]             coeff_value,
    // output channel
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [2:0]                                channel,
    output logic signed [DATA_W-1:0]                  value,
    output logic                                      last,
    // configuration
    input  wire logic [6:0]                           tap_count,
    input  wire logic                                 layout_select,
    // delay line memory
    output logic                                      h_we,
    output logic [$clog2(NUM_FILT*MAX_TAPS)-1:0]      h_waddr,
    output logic signed [DATA_W-1:0]                  h_wdata,
    output logic [$clog2(NUM_FILT*MAX_TAPS)-1:0]      h_raddr,
    // coefficient memory
    output logic                                      c_we,
    output logic [$clog2(BANK_NUM*MAX_TAPS)-1:0]      c_waddr,
    output logic signed [DATA_W-1:0]                  c_wdata,
    output logic [$clog2(BANK_NUM*MAX_TAPS)-1:0]      c_raddr,
    // MAC unit
    output mac_ctl_t                                  mac_ctl,
    output logic signed [DATA_W-1:0]                  gain_x,
    input  wire logic                                 res_vld,
    input  wire logic signed [DATA_W-1:0]             res
);

    localparam int HA_W   = $clog2(NUM_FILT*MAX_TAPS);
    localparam int CA_W   = $clog2(BANK_NUM*MAX_TAPS);
    localparam int POS_W  = $clog2(MAX_TAPS);
    localparam int CNT_W  = $clog2(MAX_TAPS + 1);
    localparam int H_LAST = NUM_FILT*MAX_TAPS - 1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_GAIN,
        ST_FWR,
        ST_MAC,
        ST_WAIT,
        ST_EMIT
    } state_t;

    state_t                      state_reg;
    logic [2:0]                  job_reg;
    logic signed [DATA_W-1:0]    left_reg;
    logic signed [DATA_W-1:0]    right_reg;
    logic signed [DATA_W-1:0]    gl_reg;
    logic signed [DATA_W-1:0]    gr_reg;
    logic signed [DATA_W-1:0]    res_reg;
    logic [POS_W-1:0]            pos_reg;
    logic [POS_W-1:0]            k_reg;
    logic [HA_W-1:0]             hbase_reg;
    logic [HA_W-1:0]             clr_reg;
    logic [POS_W-1:0]            wp_reg [NUM_FILT];
    mac_ctl_t                    ctl_reg;
    logic                        out_valid_reg;
    logic [2:0]                  channel_reg;
    logic signed [DATA_W-1:0]    value_reg;
    logic                        last_reg;

    logic [CNT_W-1:0]            n_taps;
    logic [2:0]                  filt;
    logic [POS_W-1:0]            cur_wp;
    logic [POS_W-1:0]            k_top;
    logic [CA_W-1:0]             cbase;
    logic [CA_W-1:0]             lbase;
    logic [2:0]                  out_pos;
    logic                        out_free;
    logic                        load_ok;

    // taps in use: zero counts as one, capped at the delay line length
    always_comb
    begin
        if (tap_count == 7'd0)
            n_taps = CNT_W'(1);
        else if (32'(tap_count) > MAX_TAPS)
            n_taps = CNT_W'(MAX_TAPS);
        else
            n_taps = CNT_W'(tap_count);
    end
    assign k_top = POS_W'(n_taps - CNT_W'(1));

    // advance a circular position
    function automatic logic [POS_W-1:0] bump(input logic [POS_W-1:0] p,
                                              input logic [CNT_W-1:0] n);
        logic [POS_W:0] inc;
        inc = {1'b0, p} + 1'b1;
        if (32'(inc) >= 32'(n))
            return '0;
        return inc[POS_W-1:0];
    endfunction

    function automatic logic [CA_W-1:0] bank_base(input logic [1:0] b);
        logic [CA_W-1:0] r;
        case (b)
            BANK_LP: r = '0;
            BANK_HP: r = CA_W'(MAX_TAPS);
            BANK_BP: r = CA_W'(2*MAX_TAPS);
            default: r = '0;
        endcase
        return r;
    endfunction

    assign filt   = job_reg - 3'd2;
    assign cur_wp = (filt < 3'(NUM_FILT)) ? wp_reg[filt] : '0;
    assign cbase  = bank_base(filt_bank(filt));
    assign lbase  = bank_base(coeff_bank);
    assign load_ok = (coeff_bank != BANK_NUM) && (32'(coeff_index) < MAX_TAPS);
    assign out_pos = (job_reg == 3'd0) ? 3'd0 : job_reg - 3'd1;
    assign out_free = !out_valid_reg || !out_stall;

    // memory ports
    always_comb
    begin
        h_we    = 1'b0;
        h_waddr = clr_reg;
        h_wdata = '0;
        if (state_reg == ST_CLEAR)
        begin
            h_we = 1'b1;
        end
        else if (state_reg == ST_FWR)
        begin
            h_we    = 1'b1;
            h_waddr = hbase_reg + HA_W'(cur_wp);
            h_wdata = (filt < 3'd3) ? gl_reg : gr_reg;
        end
    end
    assign h_raddr = hbase_reg + HA_W'(pos_reg);
    assign c_we    = (state_reg == ST_IDLE) && in_valid && (mode == MODE_LOAD) && load_ok;
    assign c_waddr = lbase + CA_W'(coeff_index);
    assign c_wdata = coeff_value;
    assign c_raddr = cbase + CA_W'(k_reg);

    assign mac_ctl   = ctl_reg;
    assign gain_x    = job_reg[0] ? right_reg : left_reg;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign channel   = channel_reg;
    assign value     = value_reg;
    assign last      = last_reg;

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            job_reg       <= '0;
            clr_reg       <= '0;
            hbase_reg     <= '0;
            ctl_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_FILT; i++)
            begin
                wp_reg[i] <= '0;
            end
        end
        else
        begin
            ctl_reg <= '0;
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == HA_W'(H_LAST))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (in_valid && (mode == MODE_PAIR))
                    begin
                        left_reg  <= sample_left;
                        right_reg <= sample_right;
                        job_reg   <= '0;
                        state_reg <= ST_GAIN;
                    end
                end
                ST_GAIN:
                begin
                    ctl_reg   <= '{vld: 1'b1, first: 1'b1, last: 1'b1, gain: 1'b1};
                    state_reg <= ST_WAIT;
                end
                ST_FWR:
                begin
                    pos_reg   <= bump(cur_wp, n_taps);
                    k_reg     <= k_top;
                    state_reg <= ST_MAC;
                end
                ST_MAC:
                begin
                    ctl_reg <= '{vld: 1'b1, first: (k_reg == k_top),
                                 last: (k_reg == '0), gain: 1'b0};
                    pos_reg <= bump(pos_reg, n_taps);
                    k_reg   <= k_reg - 1'b1;
                    if (k_reg == '0)
                    begin
                        wp_reg[filt] <= bump(pos_reg, n_taps);
                        state_reg    <= ST_WAIT;
                    end
                end
                ST_WAIT:
                begin
                    if (res_vld)
                    begin
                        res_reg <= res;
                        case (job_reg)
                            3'd0:
                            begin
                                gl_reg    <= res;
                                state_reg <= ST_EMIT;
                            end
                            3'd1:
                            begin
                                gr_reg    <= res;
                                job_reg   <= 3'd2;
                                hbase_reg <= '0;
                                state_reg <= ST_FWR;
                            end
                            default:
                            begin
                                state_reg <= ST_EMIT;
                            end
                        endcase
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        channel_reg   <= {2'b00, ~layout_select} + out_pos;
                        value_reg     <= res_reg;
                        last_reg      <= (job_reg == 3'd7);
                        job_reg       <= job_reg + 1'b1;
                        if (job_reg == 3'd7)
                            state_reg <= ST_IDLE;
                        else if (job_reg == 3'd0)
                            state_reg <= ST_GAIN;
                        else
                        begin
                            hbase_reg <= hbase_reg + HA_W'(MAX_TAPS);
                            state_reg <= ST_FWR;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/stereo_fir_filter_bank.sv =====
// ----------------------------------------------------------------------------
// stereo_fir_filter_bank
// Pre-gain and six FIR filters on stereo Q1.31 samples, one shared MAC.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): a beat is either a stereo sample pair
// (mode 0) or a coefficient load (mode 1, one tap of one bank).
// A load is taken without raising in_stall and gives no output.
// A pair gives seven output beats (out_valid / out_stall): gained left, left
// through LP, HP, BP, then right through BP, HP, LP; last marks the seventh.
// Every tap of every filter is one pass through the single MAC, and each
// filter adds a delay line write plus the MAC pipeline drain.
// While a pair is in work in_stall is high; the next beat is taken as soon
// as the seventh result sits in the output register.
// A stalled receiver holds the output register, and the sequencer waits with
// its next result until the register frees.
// After reset the delay lines are cleared, one entry a cycle, all 6*MAX_TAPS
// entries, with in_stall high; configuration writes are taken meanwhile.
// Coefficients are undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_fir_filter_bank
    import sfb_pkg::*;
#(
    parameter int MAX_TAPS = 64
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // configuration
    input  wire logic                         cfg_we,
    input  wire logic [CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [DATA_W-1:0]            cfg_data,
    // input channel
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic                         mode,
    input  wire logic signed [DATA_W-1:0]     sample_left,
    input  wire logic signed [DATA_W-1:0]     sample_right,
    input  wire logic [1:0]                   coeff_bank,
    input  wire logic [5:0]                   coeff_index,
    input  wire logic signed [DATA_W-1:0]     coeff_value,
    // output channel
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [2:0]                        channel,
    output logic signed [DATA_W-1:0]          value,
    output logic                              last
);

    localparam int HA_W = $clog2(NUM_FILT*MAX_TAPS);
    localparam int CA_W = $clog2(BANK_NUM*MAX_TAPS);

    logic signed [DATA_W-1:0] pre_gain_reg;
    logic [6:0]               tap_count_reg;
    logic                     layout_reg;

    logic                     h_we;
    logic [HA_W-1:0]          h_waddr;
    logic signed [DATA_W-1:0] h_wdata;
    logic [HA_W-1:0]          h_raddr;
    logic signed [DATA_W-1:0] h_rdata;
    logic                     c_we;
    logic [CA_W-1:0]          c_waddr;
    logic signed [DATA_W-1:0] c_wdata;
    logic [CA_W-1:0]          c_raddr;
    logic signed [DATA_W-1:0] c_rdata;
    mac_ctl_t                 mac_ctl;
    logic signed [DATA_W-1:0] gain_x;
    logic                     res_vld;
    logic signed [DATA_W-1:0] res;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_gain_reg  <= 32'sh7fff_ffff;
            tap_count_reg <= 7'd64;
            layout_reg    <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PRE_GAIN:  pre_gain_reg  <= cfg_data;
                CFG_TAP_COUNT: tap_count_reg <= cfg_data[6:0];
                CFG_LAYOUT:    layout_reg    <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    sfb_ctrl #(.MAX_TAPS(MAX_TAPS)) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .sample_left   (sample_left),
        .sample_right  (sample_right),
        .coeff_bank    (coeff_bank),
        .coeff_index   (coeff_index),
        .coeff_value   (coeff_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .channel       (channel),
        .value         (value),
        .last          (last),
        .tap_count     (tap_count_reg),
        .layout_select (layout_reg),
        .h_we          (h_we),
        .h_waddr       (h_waddr),
        .h_wdata       (h_wdata),
        .h_raddr       (h_raddr),
        .c_we          (c_we),
        .c_waddr       (c_waddr),
        .c_wdata       (c_wdata),
        .c_raddr       (c_raddr),
        .mac_ctl       (mac_ctl),
        .gain_x        (gain_x),
        .res_vld       (res_vld),
        .res           (res)
    );

    // delay lines of all six filters
    sfb_ram #(.WIDTH(DATA_W), .DEPTH(NUM_FILT*MAX_TAPS)) u_hist_ram (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    // three coefficient banks
    sfb_ram #(.WIDTH(DATA_W), .DEPTH(BANK_NUM*MAX_TAPS)) u_coef_ram (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    sfb_mac #(.MAX_TAPS(MAX_TAPS)) u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (mac_ctl),
        .gain_x   (gain_x),
        .pre_gain (pre_gain_reg),
        .coef     (c_rdata),
        .hist     (h_rdata),
        .res_vld  (res_vld),
        .res      (res)
    );

    // MAC work only while a pair is in progress
    a_mac_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mac_ctl.vld |-> in_stall)
        else $error("MAC issue while input side idle");

    a_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_vld |-> in_stall)
        else $error("MAC result while input side idle");

    // the seventh beat of a pair carries the top channel number
    a_last_chan: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last) |-> (channel == ({2'b00, ~layout_reg} + 3'd6)))
        else $error("last beat on wrong channel");

    // coefficient writes only from an accepted load beat
    a_coef_wr: assert property (@(posedge clk) disable iff (!rst_n)
        c_we |-> (in_valid && !in_stall && (mode == MODE_LOAD)))
        else $error("coefficient write without load beat");

endmodule

`default_nettype wire
